>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ATRW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ATRW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/atrw_pkg.sv
package atrw_pkg;

   localparam int DEF_MAX_PERIOD = 64;
   localparam int DEF_PRICE_BITS = 32;

   localparam int FIELD_BITS  = 32;
   localparam int PERIOD_BITS = 7;
   localparam int AVG_BITS    = 40;
   localparam int FRAC_BITS   = 8;

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 7'd14;

   typedef struct packed {
      logic [FIELD_BITS-1:0] bar_high;
      logic [FIELD_BITS-1:0] bar_low;
      logic [FIELD_BITS-1:0] bar_close;
   } atrw_req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] bar_range;
      logic                  range_valid;
      logic [AVG_BITS-1:0]   avg_range_q8;
      logic                  avg_valid;
   } atrw_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANGE,
      ST_UPDATE,
      ST_CHECK,
      ST_DIV,
      ST_OUT
   } atrw_state_type;

endpackage

>>> rtl/core/atrw_ram.sv
module atrw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/atrw_div.sv
module atrw_div import atrw_pkg::*; #(
   parameter int DIVIDEND_BITS = 46,
   parameter int DIVISOR_BITS  = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(DIVIDEND_BITS);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIVISOR_BITS'(trial - {1'b0, dsr_ff}) : DIVISOR_BITS'(trial);
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/core/average_true_range_window_core.sv
// A bar without a full window skips the divider; a bar with one waits for the
// one-bit-per-cycle divider, which divides the window sum by the period.
// The core takes a new bar only in ST_IDLE, after the last result is registered.
// Reset: synchronous; period 14, history and previous close cleared, no memory sweep.
`include "assert_macros.svh"

module average_true_range_window_core import atrw_pkg::*; #(
   parameter int MAX_PERIOD = DEF_MAX_PERIOD,
   parameter int PRICE_BITS = DEF_PRICE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  atrw_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output atrw_rsp_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [PERIOD_BITS-1:0] csr_wdata
);

   localparam int AW  = $clog2(MAX_PERIOD);
   localparam int PW  = $clog2(MAX_PERIOD + 1);
   localparam int CW  = (PW > PERIOD_BITS) ? PW : PERIOD_BITS;
   localparam int SW  = PRICE_BITS + $clog2(MAX_PERIOD);
   localparam int DW  = SW + FRAC_BITS;

   atrw_state_type state_ff, state_in;

   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [PRICE_BITS-1:0]  hi_ff, hi_in, lo_ff, lo_in, cl_ff, cl_in;
   logic [PRICE_BITS-1:0]  last_close_ff, last_close_in;
   logic                   have_ff, have_in;
   logic [PRICE_BITS-1:0]  tr_ff, tr_in;
   logic                   rv_ff, rv_in;
   logic [SW-1:0]          sum_ff, sum_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [PW-1:0]          seen_ff, seen_in;
   logic [AVG_BITS-1:0]    avg_ff, avg_in;
   logic                   av_ff, av_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   atrw_rsp_type           rsp_ff, rsp_in;

   logic [CW-1:0]          period_ext;
   logic [PW-1:0]          eff_p;
   logic                   full;
   logic [PW-1:0]          pos_next;
   logic [PRICE_BITS-1:0]  d_a, d_b, d_c, tr_max;
   logic                   req_fire, csr_fire, out_free;
   logic                   ram_we, div_start, div_done;
   logic [PRICE_BITS-1:0]  ram_rdata;
   logic [DW-1:0]          quotient;

   assign period_ext = CW'(period_ff);
   always_comb begin
      if (period_ext == '0) begin
         eff_p = PW'(1);
      end else if (period_ext > CW'(MAX_PERIOD)) begin
         eff_p = PW'(MAX_PERIOD);
      end else begin
         eff_p = PW'(period_ext);
      end
   end

   assign full     = seen_ff >= eff_p;
   assign pos_next = PW'(pos_ff) + PW'(1);
   assign req_fire = req_valid && req_ready;
   assign csr_fire = csr_valid && csr_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign d_a    = (hi_ff > lo_ff) ? hi_ff - lo_ff : '0;
   assign d_b    = (hi_ff >= last_close_ff) ? hi_ff - last_close_ff : last_close_ff - hi_ff;
   assign d_c    = (lo_ff >= last_close_ff) ? lo_ff - last_close_ff : last_close_ff - lo_ff;
   always_comb begin
      tr_max = d_a;
      if (d_b > tr_max) begin
         tr_max = d_b;
      end
      if (d_c > tr_max) begin
         tr_max = d_c;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            state_in = have_ff ? ST_UPDATE : ST_CHECK;
         end
         ST_UPDATE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = full ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      csr_ready = 1'b0;
      ram_we    = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            csr_ready = 1'b1;
         end
         ST_UPDATE: begin
            ram_we = 1'b1;
         end
         ST_CHECK: begin
            div_start = full;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      period_in     = period_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      cl_in         = cl_ff;
      last_close_in = last_close_ff;
      have_in       = have_ff;
      tr_in         = tr_ff;
      rv_in         = rv_ff;
      sum_in        = sum_ff;
      pos_in        = pos_ff;
      seen_in       = seen_ff;
      avg_in        = avg_ff;
      av_in         = av_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         hi_in = PRICE_BITS'(req_data.bar_high);
         lo_in = PRICE_BITS'(req_data.bar_low);
         cl_in = PRICE_BITS'(req_data.bar_close);
      end
      if (csr_fire) begin
         period_in = csr_wdata;
         sum_in    = '0;
         pos_in    = '0;
         seen_in   = '0;
      end

      case (state_ff)
         ST_RANGE: begin
            tr_in         = have_ff ? tr_max : '0;
            rv_in         = have_ff;
            last_close_in = cl_ff;
            have_in       = 1'b1;
         end
         ST_UPDATE: begin
            sum_in  = sum_ff - (full ? SW'(ram_rdata) : SW'(0)) + SW'(tr_ff);
            pos_in  = (pos_next >= eff_p) ? '0 : AW'(pos_next);
            seen_in = full ? seen_ff : seen_ff + PW'(1);
         end
         ST_CHECK: begin
            avg_in = '0;
            av_in  = full;
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in = AVG_BITS'(quotient);
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in.bar_range    = FIELD_BITS'(tr_ff);
               rsp_in.range_valid  = rv_ff;
               rsp_in.avg_range_q8 = avg_ff;
               rsp_in.avg_valid    = av_ff;
               rsp_valid_in        = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         period_ff     <= PERIOD_RESET;
         last_close_ff <= '0;
         have_ff       <= 1'b0;
         sum_ff        <= '0;
         pos_ff        <= '0;
         seen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         period_ff     <= period_in;
         last_close_ff <= last_close_in;
         have_ff       <= have_in;
         sum_ff        <= sum_in;
         pos_ff        <= pos_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cl_ff  <= cl_in;
      tr_ff  <= tr_in;
      rv_ff  <= rv_in;
      avg_ff <= avg_in;
      av_ff  <= av_in;
      rsp_ff <= rsp_in;
   end

   atrw_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (MAX_PERIOD)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (tr_ff),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   atrw_div #(
      .DIVIDEND_BITS (DW),
      .DIVISOR_BITS  (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_ff, FRAC_BITS'(0)}),
      .divisor  (eff_p),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ATRW_ASSERT(a_seen_bound, clock, reset, seen_ff <= eff_p || $past(csr_fire), "ranges seen above period")
   `ATRW_ASSERT(a_pos_bound, clock, reset, PW'(pos_ff) < PW'(MAX_PERIOD), "ring position out of range")
   `ATRW_ASSERT(a_div_done_state, clock, reset, div_done |-> state_ff == ST_DIV, "divider done outside division")
   `ATRW_ASSERT(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT), "result raised outside output step")

endmodule
